// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// ===== rtl/xdkc_pkg.sv =====
`timescale 1ns / 1ps
package xdkc_pkg;

   localparam int MAX_K_DEFAULT   = 16;
   localparam int ID_BITS_DEFAULT = 64;

   localparam int DATA_W     = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int NCOUNT_W   = 5;

   localparam logic [0:0] REG_TARGET_ID      = 1'b0;
   localparam logic [0:0] REG_NEIGHBOR_COUNT = 1'b1;

   localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 5'd16;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic insert;
      logic pop;
      logic pop_last;
      logic clear;
   } dp_cmd_type;

endpackage

// ===== rtl/xor_distance_k_closest.sv =====
`timescale 1ns / 1ps
// XOR-distance k-closest selector.
// req channel: one node identifier per item on req_tdata, req_tlast on the final
// node of a set. While collecting, req_tready is high and one item is taken
// every cycle; each node is compared against all MAX_K kept entries at once and
// inserted in distance order (distance = node XOR target, unsigned), repeats once.
// After the item with req_tlast, req_tready drops and the nearest
// min(neighbor_count, kept) identifiers leave on rsp, nearest first, rsp_tlast on
// the final one. After the last item is taken, the state moves to emit and the first
// result is loaded into the output register; then one result per cycle while
// rsp_tready is high. Collecting resumes the cycle after the final result is loaded
// into the output register. An empty or zero-count set emits nothing.
// A stalled receiver holds the output register and pauses the drain.
// csr: target_id at byte 0x0, neighbor_count at 0x8 (reset 16, saturates at MAX_K);
// write only while idle. Reset empties the list and clears the output valid.
module xor_distance_k_closest #(
   parameter int MAX_K   = xdkc_pkg::MAX_K_DEFAULT,
   parameter int ID_BITS = xdkc_pkg::ID_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [xdkc_pkg::DATA_W-1:0]      req_tdata,  // [63:0] node_id
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [xdkc_pkg::DATA_W-1:0]      rsp_tdata,  // [63:0] neighbor_id
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [xdkc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [xdkc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [xdkc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import xdkc_pkg::*;

   localparam int CW = $clog2(MAX_K + 1);

   logic [ID_BITS-1:0]  target_id;
   logic [NCOUNT_W-1:0] neighbor_count;
   logic [CW-1:0]       count_next;
   logic [ID_BITS-1:0]  out_id;
   dp_cmd_type          cmd;

   xdkc_csr #(
      .ID_BITS(ID_BITS)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .target_id      (target_id),
      .neighbor_count (neighbor_count)
   );

   xdkc_ctrl #(
      .MAX_K(MAX_K),
      .CW   (CW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tlast      (req_tlast),
      .req_tready     (req_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .neighbor_count (neighbor_count),
      .count_next     (count_next),
      .cmd            (cmd)
   );

   xdkc_datapath #(
      .MAX_K  (MAX_K),
      .ID_BITS(ID_BITS),
      .CW     (CW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .node_id    (req_tdata),
      .target_id  (target_id),
      .count_next (count_next),
      .out_id     (out_id),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = DATA_W'(out_id);

endmodule

// ===== rtl/xdkc_csr.sv =====
`timescale 1ns / 1ps
module xdkc_csr #(
   parameter int ID_BITS = xdkc_pkg::ID_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [xdkc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [xdkc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [xdkc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [ID_BITS-1:0]               target_id,
   output logic [xdkc_pkg::NCOUNT_W-1:0]    neighbor_count
);
   import xdkc_pkg::*;

   logic [ID_BITS-1:0]  target_ff;
   logic [ID_BITS-1:0]  target_in;
   logic [NCOUNT_W-1:0] ncount_ff;
   logic [NCOUNT_W-1:0] ncount_in;
   logic                wr_en;
   logic [0:0]          reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3:3];

   always_comb begin
      target_in = target_ff;
      ncount_in = ncount_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TARGET_ID:      target_in = csr_pwdata[ID_BITS-1:0];
            REG_NEIGHBOR_COUNT: ncount_in = csr_pwdata[NCOUNT_W-1:0];
            default:            target_in = target_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         ncount_ff <= NCOUNT_RESET;
      end else begin
         target_ff <= target_in;
         ncount_ff <= ncount_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TARGET_ID:      csr_prdata = CSR_DATA_W'(target_ff);
         REG_NEIGHBOR_COUNT: csr_prdata = CSR_DATA_W'(ncount_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign target_id      = target_ff;
   assign neighbor_count = ncount_ff;

endmodule

// ===== rtl/xdkc_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module xdkc_datapath #(
   parameter int MAX_K   = xdkc_pkg::MAX_K_DEFAULT,
   parameter int ID_BITS = xdkc_pkg::ID_BITS_DEFAULT,
   parameter int CW      = $clog2(MAX_K + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  xdkc_pkg::dp_cmd_type         cmd,
   input  logic [xdkc_pkg::DATA_W-1:0]  node_id,
   input  logic [ID_BITS-1:0]           target_id,
   output logic [CW-1:0]                count_next,
   output logic [ID_BITS-1:0]           out_id,
   output logic                         out_last
);
   import xdkc_pkg::*;

   logic [ID_BITS-1:0] ids_ff   [MAX_K];
   logic [ID_BITS-1:0] ids_in   [MAX_K];
   logic [ID_BITS-1:0] kdist    [MAX_K];
   logic [ID_BITS-1:0] up_id    [MAX_K];
   logic [ID_BITS-1:0] down_id  [MAX_K];
   logic [MAX_K-1:0]   valid;
   logic [MAX_K-1:0]   ge;
   logic [MAX_K-1:0]   eq;
   logic [MAX_K-1:0]   prev_ge;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [ID_BITS-1:0] out_id_ff;
   logic               out_last_ff;
   logic [ID_BITS-1:0] cand;
   logic [ID_BITS-1:0] cand_dist;
   logic               dup;
   logic               grow;

   assign cand      = node_id[ID_BITS-1:0];
   assign cand_dist = cand ^ target_id;

   for (genvar g = 0; g < MAX_K; g++) begin : g_entry
      assign valid[g] = CW'(g) < count_ff;
      assign kdist[g] = ids_ff[g] ^ target_id;
      assign ge[g]    = valid[g] && (cand_dist > kdist[g]);
      assign eq[g]    = valid[g] && (cand_dist == kdist[g]);
      if (g == 0) begin : g_head
         assign prev_ge[g] = 1'b1;
         assign up_id[g]   = cand;
      end else begin : g_body
         assign prev_ge[g] = ge[g-1];
         assign up_id[g]   = ids_ff[g-1];
      end
      if (g == MAX_K - 1) begin : g_tail
         assign down_id[g] = ids_ff[g];
      end else begin : g_mid
         assign down_id[g] = ids_ff[g+1];
      end
   end

   assign dup  = |eq;
   assign grow = cmd.insert && !dup && (count_ff < CW'(MAX_K));
   assign count_next = count_ff + CW'(grow);

   always_comb begin
      for (int i = 0; i < MAX_K; i++) begin
         ids_in[i] = ids_ff[i];
         if (cmd.insert && !dup && !ge[i]) begin
            ids_in[i] = prev_ge[i] ? cand : up_id[i];
         end else if (cmd.pop) begin
            ids_in[i] = down_id[i];
         end
      end
   end

   always_comb begin
      count_in = count_next;
      if (cmd.clear) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      ids_ff <= ids_in;
      if (cmd.pop) begin
         out_id_ff   <= ids_ff[0];
         out_last_ff <= cmd.pop_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_id   = out_id_ff;
   assign out_last = out_last_ff;

   `ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear, count_ff == '0)

endmodule

// ===== rtl/xdkc_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module xdkc_ctrl #(
   parameter int MAX_K = xdkc_pkg::MAX_K_DEFAULT,
   parameter int CW    = $clog2(MAX_K + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tlast,
   output logic                           req_tready,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [xdkc_pkg::NCOUNT_W-1:0]  neighbor_count,
   input  logic [CW-1:0]                  count_next,
   output xdkc_pkg::dp_cmd_type           cmd
);
   import xdkc_pkg::*;

   localparam int CMPW = (CW > NCOUNT_W) ? CW : NCOUNT_W;

   state_type   state_ff;
   state_type   state_in;
   logic [CW-1:0] remaining_ff;
   logic [CW-1:0] remaining_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          accept;
   logic          out_free;
   logic [CW-1:0] sat_count;
   logic [CW-1:0] emit_count;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;

   assign sat_count  = (CMPW'(neighbor_count) > CMPW'(MAX_K)) ? CW'(MAX_K)
                                                              : CW'(neighbor_count);
   assign emit_count = (sat_count < count_next) ? sat_count : count_next;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (accept && req_tlast) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.clear) begin
               state_in = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            cmd.insert = req_tvalid;
         end
         ST_EMIT: begin
            cmd.pop      = (remaining_ff != '0) && out_free;
            cmd.pop_last = remaining_ff == CW'(1);
            cmd.clear    = (remaining_ff == '0) || (cmd.pop_last && out_free);
         end
         default: req_tready = 1'b0;
      endcase
   end

   always_comb begin
      remaining_in = remaining_ff;
      if (accept && req_tlast) begin
         remaining_in = emit_count;
      end else if (cmd.pop) begin
         remaining_in = remaining_ff - CW'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_NEXT(a_last_starts_emit, clock, reset, accept && req_tlast, state_ff == ST_EMIT)
   `ASSERT_NEXT(a_pop_shows_item, clock, reset, cmd.pop, rsp_valid_ff)
   `ASSERT_IMPLIES(a_pop_only_with_room, clock, reset, cmd.pop,
                   state_ff == ST_EMIT && out_free && !req_tready)

endmodule
